>>> hdl/i2cms_pkg.sv
package i2cms_pkg;

	// Operation carried by an input word.
	typedef enum logic [1:0] {
		OP_TXLOAD  = 2'd0,
		OP_REQUEST = 2'd1,
		OP_EVENT   = 2'd2,
		OP_DRAIN   = 2'd3
	} op_t;

	// Link status as reported to the host.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_BUSY   = 2'd1,
		PH_FAILED = 2'd2,
		PH_DATAV  = 2'd3
	} phase_t;

	// Transfer direction requested by the host.
	localparam logic [1:0] MODE_WRITE      = 2'd0;
	localparam logic [1:0] MODE_READ       = 2'd1;
	localparam logic [1:0] MODE_WRITE_READ = 2'd2;

	// Bus controller status codes.
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_RESTART      = 8'h10;
	localparam logic [7:0] ST_ADDR_W_ACK   = 8'h18;
	localparam logic [7:0] ST_ADDR_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_ADDR_R_ACK   = 8'h40;
	localparam logic [7:0] ST_ADDR_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;
	localparam logic [7:0] READ_BIT        = 8'h01;

	// Most result words one drain may hand out.
	localparam int DRAIN_LIMIT = 16;

	// Input word.
	typedef struct packed {
		op_t        op;
		logic [3:0] tx_index;
		logic [7:0] tx_byte;
		logic [6:0] peer_address;
		logic [1:0] mode;
		logic [4:0] send_count;
		logic [4:0] receive_count;
		logic [7:0] status_code;
		logic [7:0] rx_data;
		logic [4:0] drain_count;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic       load_data;
		logic [7:0] data_out;
		logic       set_start;
		logic       set_stop;
		logic       set_ack;
		logic       clear_ack;
		phase_t     link_status;
		logic       accepted;
		logic [7:0] read_byte;
		logic [6:0] source_address;
		logic       last;
	} out_word_t;

	// Bus actions produced by one request or status event.
	typedef struct packed {
		logic       load;
		logic [7:0] dout;
		logic       sta;
		logic       sto;
		logic       ack;
		logic       nack;
		logic       acc;
	} act_res_t;

	// Microprogram addresses.
	typedef enum logic [3:0] {
		U_FETCH  = 4'd0,
		U_TXWR   = 4'd1,
		U_REQ    = 4'd2,
		U_EVRD   = 4'd3,
		U_EVT    = 4'd4,
		U_EMIT   = 4'd5,
		U_DRINIT = 4'd6,
		U_DRRD   = 4'd7,
		U_DROUT  = 4'd8
	} upc_t;

	// Datapath action selected by a control word.
	typedef enum logic [3:0] {
		A_NONE   = 4'd0,
		A_FETCH  = 4'd1,
		A_TXWR   = 4'd2,
		A_REQ    = 4'd3,
		A_EVRD   = 4'd4,
		A_EVT    = 4'd5,
		A_DRINIT = 4'd6,
		A_DRRD   = 4'd7,
		A_DROUT  = 4'd8
	} act_t;

	// How the step counter moves on.
	typedef enum logic [1:0] {
		Q_NEXT     = 2'd0,
		Q_DISPATCH = 2'd1,
		Q_HOLD     = 2'd2,
		Q_LOOP     = 2'd3
	} seq_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic take;
		logic emit;
		act_t act;
		seq_t seq;
		upc_t target;
		upc_t alt;
	} ctrl_t;

	// Microprogram ROM. The loop step goes to target on the last word and to alt otherwise.
	function automatic ctrl_t ucode(upc_t pc);
		ctrl_t cw;
		unique case (pc)
			U_FETCH:  cw = '{1'b1, 1'b0, A_FETCH,  Q_DISPATCH, U_FETCH, U_FETCH};
			U_TXWR:   cw = '{1'b0, 1'b0, A_TXWR,   Q_NEXT,     U_EMIT,  U_EMIT};
			U_REQ:    cw = '{1'b0, 1'b0, A_REQ,    Q_NEXT,     U_EMIT,  U_EMIT};
			U_EVRD:   cw = '{1'b0, 1'b0, A_EVRD,   Q_NEXT,     U_EVT,   U_EVT};
			U_EVT:    cw = '{1'b0, 1'b0, A_EVT,    Q_NEXT,     U_EMIT,  U_EMIT};
			U_EMIT:   cw = '{1'b0, 1'b1, A_NONE,   Q_HOLD,     U_FETCH, U_FETCH};
			U_DRINIT: cw = '{1'b0, 1'b0, A_DRINIT, Q_NEXT,     U_DRRD,  U_DRRD};
			U_DRRD:   cw = '{1'b0, 1'b0, A_DRRD,   Q_NEXT,     U_DROUT, U_DROUT};
			U_DROUT:  cw = '{1'b0, 1'b1, A_DROUT,  Q_LOOP,     U_FETCH, U_DRRD};
			default:  cw = '{1'b0, 1'b0, A_NONE,   Q_NEXT,     U_FETCH, U_FETCH};
		endcase
		return cw;
	endfunction

endpackage

>>> hdl/i2cms_chan_if.sv
interface i2cms_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer. Each request word loads a transmit byte, starts a
// transfer, reports one bus controller status code, or drains the receive buffer. The
// block takes one word at a time and answers with one result word, or with one word
// per drained byte. A small microprogram in a ROM steps a plain datapath. A transmit
// byte load or a request passes the fetch step, its own action step and the result
// step. A status event adds a registered read of the transmit buffer before its action
// step. A drain runs an init step and then, per byte, a registered read of the receive
// buffer and an output step; an empty drain answers with one word and takes the same
// steps as a one-byte drain. A shown result is held until the sink takes it, and the
// next word can be taken in the cycle after the last result is taken.
// Both buffers are RAM arrays; the receive buffer reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed.
module i2c_master_transaction_sequencer #(
	parameter int SEND_DEPTH    = 16,
	parameter int RECEIVE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	i2cms_chan_if.sink          req,
	i2cms_chan_if.source        rsp
);
	import i2cms_pkg::*;

	localparam int SEND_AW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
	localparam int RECV_AW = $clog2(RECEIVE_DEPTH);
	localparam logic [8:0] SEND_LIM = 9'(SEND_DEPTH);
	localparam logic [8:0] RECV_LIM = 9'(RECEIVE_DEPTH);
	localparam logic [4:0] DRAIN_MAX =
		5'((RECEIVE_DEPTH < DRAIN_LIMIT) ? RECEIVE_DEPTH : DRAIN_LIMIT);

	// Step counter and the current control word.
	upc_t     upc_q;
	upc_t     upc_d;
	ctrl_t    cw;

	// Captured input word.
	in_word_t word_q;

	// Link state.
	phase_t     phase_q;
	logic [7:0] addr_byte_q;
	logic [4:0] send_total_q;
	logic [4:0] recv_total_q;
	logic [4:0] pos_q;
	logic       turn_q;
	logic [6:0] rem_addr_q;

	// Result of the last request or event.
	act_res_t   res_q;

	// Drain walk.
	logic [4:0] drn_cnt_q;
	logic [4:0] drn_idx_q;
	logic       drn_avail_q;
	logic [6:0] drn_src_q;
	logic       drn_last;

	// Buffers.
	logic [7:0]         send_mem [SEND_DEPTH];
	logic [7:0]         recv_mem [RECEIVE_DEPTH];
	logic [RECEIVE_DEPTH-1:0] recv_vld_q;
	logic [7:0]         tx_rdata_q;
	logic               tx_ok_q;
	logic [7:0]         rx_rdata_q;

	// Event evaluation.
	act_res_t   evt_res;
	phase_t     evt_phase;
	logic [4:0] evt_pos;
	logic       evt_restart;
	logic       evt_rx_we;
	logic [4:0] pos_inc;
	logic [4:0] tx_addr;
	logic [4:0] drain_n;

	assign cw       = ucode(upc_q);
	assign req.ready = cw.take;
	assign rsp.valid = cw.emit;
	assign pos_inc  = pos_q + 5'd1;
	assign drn_last = (6'(drn_idx_q) + 6'd1) >= 6'(drn_cnt_q);

	// Step counter: dispatch on the operation, hold on a stalled result, loop over a drain.
	always_comb begin
		upc_d = upc_q;
		unique case (cw.seq)
			Q_NEXT: begin
				upc_d = cw.target;
			end
			Q_DISPATCH: begin
				if (req.valid) begin
					unique case (req.data.op)
						OP_TXLOAD:  upc_d = U_TXWR;
						OP_REQUEST: upc_d = U_REQ;
						OP_EVENT:   upc_d = U_EVRD;
						OP_DRAIN:   upc_d = U_DRINIT;
					endcase
				end
			end
			Q_HOLD: begin
				if (rsp.ready) upc_d = cw.target;
			end
			Q_LOOP: begin
				if (rsp.ready) upc_d = drn_last ? cw.target : cw.alt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cw.act == A_FETCH && req.valid) begin
			word_q <= req.data;
		end
	end

	// Transmit address: the write-acknowledged code looks one byte ahead.
	assign tx_addr = (word_q.status_code == ST_DATA_W_ACK) ? pos_inc : pos_q;

	// Clamped drain length.
	always_comb begin
		drain_n = word_q.drain_count;
		if (drain_n > DRAIN_MAX) drain_n = DRAIN_MAX;
	end

	// Status event decode.
	always_comb begin
		evt_res     = '0;
		evt_phase   = phase_q;
		evt_pos     = pos_q;
		evt_restart = 1'b0;
		evt_rx_we   = 1'b0;
		unique case (word_q.status_code)
			ST_START, ST_RESTART: begin
				evt_res.load = 1'b1;
				evt_res.dout = addr_byte_q;
			end
			ST_ADDR_W_ACK: begin
				evt_res.load = 1'b1;
				evt_res.dout = tx_ok_q ? tx_rdata_q : 8'd0;
			end
			ST_ADDR_W_NACK, ST_ADDR_R_NACK: begin
				evt_res.sto = 1'b1;
				evt_phase   = PH_FAILED;
				evt_pos     = '0;
			end
			ST_DATA_W_ACK: begin
				if (pos_inc >= send_total_q) begin
					if (turn_q) begin
						evt_res.sta = 1'b1;
						evt_restart = 1'b1;
					end else begin
						evt_res.sto = 1'b1;
						evt_phase   = PH_IDLE;
					end
					evt_pos = '0;
				end else begin
					evt_res.load = 1'b1;
					evt_res.dout = tx_ok_q ? tx_rdata_q : 8'd0;
					evt_pos      = pos_inc;
				end
			end
			ST_DATA_W_NACK: begin
				evt_res.sto = 1'b1;
				evt_phase   = PH_IDLE;
				evt_pos     = '0;
			end
			ST_ARB_LOST: begin
				evt_pos = '0;
			end
			ST_ADDR_R_ACK: begin
				if (recv_total_q <= 5'd1) evt_res.nack = 1'b1;
				else evt_res.ack = 1'b1;
			end
			ST_DATA_R_ACK: begin
				evt_rx_we = 9'(pos_q) < RECV_LIM;
				evt_pos   = pos_inc;
				if ((6'(pos_inc) + 6'd1) >= 6'(recv_total_q)) evt_res.nack = 1'b1;
				else evt_res.ack = 1'b1;
			end
			ST_DATA_R_NACK: begin
				evt_rx_we   = 9'(pos_q) < RECV_LIM;
				evt_res.sto = 1'b1;
				evt_phase   = PH_DATAV;
				evt_pos     = '0;
			end
			default: begin
				evt_res = '0;
			end
		endcase
	end

	// Link state, results and the drain walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			addr_byte_q  <= '0;
			send_total_q <= '0;
			recv_total_q <= '0;
			pos_q        <= '0;
			turn_q       <= 1'b0;
			rem_addr_q   <= '0;
			res_q        <= '0;
			drn_cnt_q    <= '0;
			drn_idx_q    <= '0;
			drn_avail_q  <= 1'b0;
			drn_src_q    <= '0;
			recv_vld_q   <= '0;
		end else begin
			unique case (cw.act)
				A_TXWR: begin
					res_q <= '0;
				end
				A_REQ: begin
					res_q <= '0;
					if (phase_q != PH_BUSY && phase_q != PH_DATAV) begin
						rem_addr_q   <= word_q.peer_address;
						addr_byte_q  <= {word_q.peer_address, word_q.mode[0]};
						send_total_q <= word_q.send_count;
						recv_total_q <= word_q.receive_count;
						turn_q       <= (word_q.mode == MODE_WRITE_READ);
						phase_q      <= PH_BUSY;
						res_q.sta    <= 1'b1;
						res_q.acc    <= 1'b1;
					end
				end
				A_EVT: begin
					res_q   <= evt_res;
					phase_q <= evt_phase;
					pos_q   <= evt_pos;
					if (evt_restart) addr_byte_q <= addr_byte_q | READ_BIT;
					if (evt_rx_we) recv_vld_q[RECV_AW'(pos_q)] <= 1'b1;
				end
				A_DRINIT: begin
					drn_cnt_q   <= drain_n;
					drn_idx_q   <= '0;
					drn_avail_q <= (phase_q == PH_DATAV) && (drain_n != 5'd0);
					drn_src_q   <= rem_addr_q;
					rem_addr_q  <= '0;
					phase_q     <= PH_IDLE;
				end
				A_DROUT: begin
					if (rsp.ready) begin
						if (drn_avail_q) recv_vld_q[RECV_AW'(drn_idx_q)] <= 1'b0;
						drn_idx_q <= drn_idx_q + 5'd1;
					end
				end
				default: begin
					res_q <= res_q;
				end
			endcase
		end
	end

	// Transmit buffer: written by a load, read one step before the event is applied.
	always_ff @(posedge clk) begin
		if (cw.act == A_TXWR && (9'(word_q.tx_index) < SEND_LIM)) begin
			send_mem[SEND_AW'(word_q.tx_index)] <= word_q.tx_byte;
		end
		if (cw.act == A_EVRD) begin
			tx_rdata_q <= send_mem[SEND_AW'(tx_addr)];
			tx_ok_q    <= 9'(tx_addr) < SEND_LIM;
		end
	end

	// Receive buffer: written on received data, read one step before each drain word.
	always_ff @(posedge clk) begin
		if (cw.act == A_EVT && evt_rx_we) begin
			recv_mem[RECV_AW'(pos_q)] <= word_q.rx_data;
		end
		if (cw.act == A_DRRD) begin
			rx_rdata_q <= recv_mem[RECV_AW'(drn_idx_q)];
		end
	end

	// Result word.
	always_comb begin
		rsp.data             = '0;
		rsp.data.link_status = phase_q;
		if (upc_q == U_DROUT) begin
			rsp.data.read_byte = (drn_avail_q && recv_vld_q[RECV_AW'(drn_idx_q)]) ?
				rx_rdata_q : 8'd0;
			rsp.data.source_address = drn_src_q;
			rsp.data.last           = drn_last;
		end else begin
			rsp.data.load_data = res_q.load;
			rsp.data.data_out  = res_q.dout;
			rsp.data.set_start = res_q.sta;
			rsp.data.set_stop  = res_q.sto;
			rsp.data.set_ack   = res_q.ack;
			rsp.data.clear_ack = res_q.nack;
			rsp.data.accepted  = res_q.acc;
		end
	end

	// A word is never taken while a result is shown.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready)
		else $error("input taken while a result is pending");

	// A drain never walks past its count.
	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_DROUT |-> (drn_idx_q < drn_cnt_q) || (drn_idx_q == 5'd0))
		else $error("drain index beyond its count");

	// An accepted request always reports a busy link.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.accepted |-> rsp.data.link_status == PH_BUSY)
		else $error("accepted request without busy status");

	// A refused request leaves no accept flag.
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_REQ && (phase_q == PH_BUSY || phase_q == PH_DATAV) |=> !res_q.acc)
		else $error("request taken while busy or holding data");

	// The last drain word returns the sequencer to fetch.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == U_DROUT && rsp.ready && drn_last |=> upc_q == U_FETCH)
		else $error("drain did not end after its last word");

endmodule

>>> verif/i2cms_checker.sv
module i2cms_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  i2cms_pkg::in_word_t  req_data,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  i2cms_pkg::out_word_t rsp_data,
	output int                   fail_count,
	output int                   due_count,
	output int                   checked_count
);
	import i2cms_pkg::*;

	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 16;

	// Mirror of the sequencer state.
	logic [7:0] tx_mem [TX_DEPTH];
	logic [7:0] rx_mem [RX_DEPTH];
	phase_t     phase;
	logic [7:0] addr_byte;
	logic [4:0] tx_total;
	logic [4:0] rx_total;
	logic [4:0] pos;
	logic       turn;
	logic [6:0] last_addr;

	// Result words still owed by the block, oldest first.
	out_word_t  due_words[$];
	int         errs;
	int         checked;

	// A transmit position past the buffer reads as zero.
	function automatic logic [7:0] tx_byte_at(logic [4:0] p);
		return (int'(p) < TX_DEPTH) ? tx_mem[p[3:0]] : 8'h00;
	endfunction

	// Work out the result words caused by one input word and queue them.
	task automatic step_sequencer(input in_word_t w);
		out_word_t r;
		int        n;
		logic      avail;
		logic [6:0] src;
		r = '0;
		case (w.op)
			OP_TXLOAD: begin
				tx_mem[w.tx_index] = w.tx_byte;
			end
			OP_REQUEST: begin
				// A request is refused while busy or while received data waits.
				if (phase != PH_BUSY && phase != PH_DATAV) begin
					last_addr = w.peer_address;
					addr_byte = {w.peer_address, w.mode[0]};
					tx_total = w.send_count;
					rx_total = w.receive_count;
					turn = (w.mode == MODE_WRITE_READ);
					phase = PH_BUSY;
					r.set_start = 1'b1;
					r.accepted = 1'b1;
				end
			end
			OP_EVENT: begin
				case (w.status_code)
					ST_START, ST_RESTART: begin
						r.load_data = 1'b1;
						r.data_out = addr_byte;
					end
					ST_ADDR_W_ACK: begin
						r.load_data = 1'b1;
						r.data_out = tx_byte_at(pos);
					end
					ST_ADDR_W_NACK, ST_ADDR_R_NACK: begin
						r.set_stop = 1'b1;
						phase = PH_FAILED;
						pos = '0;
					end
					ST_DATA_W_ACK: begin
						pos = pos + 5'd1;
						if (pos >= tx_total) begin
							// Last byte sent: turn around to a read or finish.
							if (turn) begin
								r.set_start = 1'b1;
								addr_byte = addr_byte | READ_BIT;
							end else begin
								r.set_stop = 1'b1;
								phase = PH_IDLE;
							end
							pos = '0;
						end else begin
							r.load_data = 1'b1;
							r.data_out = tx_byte_at(pos);
						end
					end
					ST_DATA_W_NACK: begin
						r.set_stop = 1'b1;
						phase = PH_IDLE;
						pos = '0;
					end
					ST_ARB_LOST: begin
						pos = '0;
					end
					ST_ADDR_R_ACK: begin
						// A single-byte read must not acknowledge its only byte.
						if (rx_total <= 5'd1)
							r.clear_ack = 1'b1;
						else
							r.set_ack = 1'b1;
					end
					ST_DATA_R_ACK: begin
						if (int'(pos) < RX_DEPTH)
							rx_mem[pos[3:0]] = w.rx_data;
						pos = pos + 5'd1;
						if (int'(pos) + 1 >= int'(rx_total))
							r.clear_ack = 1'b1;
						else
							r.set_ack = 1'b1;
					end
					ST_DATA_R_NACK: begin
						if (int'(pos) < RX_DEPTH)
							rx_mem[pos[3:0]] = w.rx_data;
						r.set_stop = 1'b1;
						phase = PH_DATAV;
						pos = '0;
					end
					default: ;
				endcase
			end
			OP_DRAIN: begin
				n = int'(w.drain_count);
				if (n > RX_DEPTH)
					n = RX_DEPTH;
				if (n > DRAIN_LIMIT)
					n = DRAIN_LIMIT;
				avail = (phase == PH_DATAV);
				src = last_addr;
				phase = PH_IDLE;
				last_addr = '0;
				r.link_status = PH_IDLE;
				r.source_address = src;
				// An empty drain still answers with one closing word.
				if (n == 0) begin
					r.last = 1'b1;
					due_words.push_back(r);
				end
				for (int i = 0; i < n; i++) begin
					r.read_byte = avail ? rx_mem[i] : 8'h00;
					if (avail)
						rx_mem[i] = 8'h00;
					r.last = (i == n - 1);
					due_words.push_back(r);
				end
			end
			default: ;
		endcase
		if (w.op != OP_DRAIN) begin
			r.link_status = phase;
			due_words.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			errs++;
		end
	endtask

	// Compare each taken result word with the oldest owed one, then predict.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			foreach (tx_mem[i])
				tx_mem[i] = 8'h00;
			foreach (rx_mem[i])
				rx_mem[i] = 8'h00;
			phase = PH_IDLE;
			addr_byte = '0;
			tx_total = '0;
			rx_total = '0;
			pos = '0;
			turn = 1'b0;
			last_addr = '0;
			due_words.delete();
			errs = 0;
			checked = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_words.size() == 0) begin
					$error("result word 0x%0h arrived with none expected", rsp_data);
					errs++;
				end else begin
					want = due_words.pop_front();
					check_field("load_data", want.load_data, rsp_data.load_data);
					check_field("data_out", want.data_out, rsp_data.data_out);
					check_field("set_start", want.set_start, rsp_data.set_start);
					check_field("set_stop", want.set_stop, rsp_data.set_stop);
					check_field("set_ack", want.set_ack, rsp_data.set_ack);
					check_field("clear_ack", want.clear_ack, rsp_data.clear_ack);
					check_field("link_status", int'(want.link_status),
						int'(rsp_data.link_status));
					check_field("accepted", want.accepted, rsp_data.accepted);
					check_field("read_byte", want.read_byte, rsp_data.read_byte);
					check_field("source_address", want.source_address,
						rsp_data.source_address);
					check_field("last", want.last, rsp_data.last);
					checked++;
				end
			end
			if (req_valid && req_ready)
				step_sequencer(req_data);
		end
		fail_count <= errs;
		due_count <= due_words.size();
		checked_count <= checked;
	end

endmodule

>>> verif/testbench.sv
module testbench;

	import i2cms_pkg::*;

	localparam int WORD_TARGET = 330;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	logic clk;
	logic arst_n;
	bit   idle_on = 1'b1;
	int   words_sent = 0;
	int   directed_words = 0;
	int   cycles = 0;
	int   fail_count;
	int   due_count;
	int   checked_count;

	i2cms_chan_if #(.T(in_word_t))  req_if ();
	i2cms_chan_if #(.T(out_word_t)) rsp_if ();

	i2c_master_transaction_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	i2cms_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_if.valid),
		.req_ready     (req_if.ready),
		.req_data      (req_if.data),
		.rsp_valid     (rsp_if.valid),
		.rsp_ready     (rsp_if.ready),
		.rsp_data      (rsp_if.data),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The result side stalls at random except during the quiet stretch.
	always @(posedge clk) begin
		rsp_if.ready <= !idle_on || ($urandom_range(99) >= 35);
	end

	// Every field starts random so that unused fields toggle too.
	function automatic in_word_t fresh_word();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return in_word_t'(bits[$bits(in_word_t)-1:0]);
	endfunction

	function automatic in_word_t mk_load(logic [3:0] idx, logic [7:0] b);
		in_word_t w;
		w = fresh_word();
		w.op = OP_TXLOAD;
		w.tx_index = idx;
		w.tx_byte = b;
		return w;
	endfunction

	function automatic in_word_t mk_request(logic [6:0] addr, logic [1:0] mode,
		logic [4:0] sc, logic [4:0] rc);
		in_word_t w;
		w = fresh_word();
		w.op = OP_REQUEST;
		w.peer_address = addr;
		w.mode = mode;
		w.send_count = sc;
		w.receive_count = rc;
		return w;
	endfunction

	function automatic in_word_t mk_status(logic [7:0] code, logic [7:0] rx);
		in_word_t w;
		w = fresh_word();
		w.op = OP_EVENT;
		w.status_code = code;
		w.rx_data = rx;
		return w;
	endfunction

	function automatic in_word_t mk_drain(logic [4:0] n);
		in_word_t w;
		w = fresh_word();
		w.op = OP_DRAIN;
		w.drain_count = n;
		return w;
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic put_word(input in_word_t w);
		idle_on = !(words_sent >= 150 && words_sent < 230);
		while (idle_on && $urandom_range(99) < 35) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= w;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		words_sent++;
	endtask

	// One well-formed transfer with random content, now and then cut short.
	task automatic run_transfer();
		logic [1:0] mode;
		logic [4:0] sc;
		logic [4:0] rc;
		int         writes;
		mode = 2'($urandom_range(0, 3));
		sc = ($urandom_range(7) == 0) ? 5'd16 : 5'($urandom_range(0, 4));
		if ($urandom_range(15) == 0)
			rc = 5'($urandom);
		else if ($urandom_range(7) == 0)
			rc = 5'd16;
		else
			rc = 5'($urandom_range(0, 4));
		put_word(mk_request(7'($urandom), mode, sc, rc));
		if ($urandom_range(9) == 0)
			put_word(mk_request(7'($urandom), 2'($urandom), 5'($urandom), 5'($urandom)));
		put_word(mk_status(ST_START, 8'($urandom)));
		if (mode == MODE_WRITE || mode == MODE_WRITE_READ) begin
			if ($urandom_range(19) == 0) begin
				put_word(mk_status(ST_ADDR_W_NACK, 8'($urandom)));
				return;
			end
			put_word(mk_status(ST_ADDR_W_ACK, 8'($urandom)));
			writes = (sc == 0) ? 1 : int'(sc);
			for (int i = 0; i < writes; i++) begin
				if ($urandom_range(29) == 0) begin
					put_word(mk_status(ST_DATA_W_NACK, 8'($urandom)));
					return;
				end
				put_word(mk_status(ST_DATA_W_ACK, 8'($urandom)));
			end
			if (mode == MODE_WRITE)
				return;
			put_word(mk_status(ST_RESTART, 8'($urandom)));
		end
		if ($urandom_range(19) == 0) begin
			put_word(mk_status(ST_ADDR_R_NACK, 8'($urandom)));
			return;
		end
		put_word(mk_status(ST_ADDR_R_ACK, 8'($urandom)));
		for (int i = 1; i < int'(rc); i++)
			put_word(mk_status(ST_DATA_R_ACK, 8'($urandom)));
		put_word(mk_status(ST_DATA_R_NACK, 8'($urandom)));
		if ($urandom_range(3) == 0)
			put_word(mk_drain(5'($urandom)));
		else
			put_word(mk_drain(rc));
	endtask

	initial begin
		in_word_t w;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole transmit buffer first, with both byte extremes.
		for (int i = 0; i < 16; i++)
			put_word(mk_load(4'(i), (i == 0) ? 8'h00 :
				(i == 15) ? 8'hFF : 8'($urandom_range(1, 254))));

		// Drain with nothing stored, and a status code the block ignores.
		put_word(mk_drain(5'd0));
		put_word(mk_status(8'hFF, 8'h00));

		// Write-then-read of one byte each way, with refusals while busy and full.
		put_word(mk_request(7'h7F, MODE_WRITE_READ, 5'd1, 5'd1));
		put_word(mk_request(7'h00, MODE_WRITE, 5'd2, 5'd0));
		put_word(mk_status(ST_START, 8'h00));
		put_word(mk_status(ST_ADDR_W_ACK, 8'h00));
		put_word(mk_status(ST_DATA_W_ACK, 8'h00));
		put_word(mk_status(ST_RESTART, 8'h00));
		put_word(mk_status(ST_ADDR_R_ACK, 8'h00));
		put_word(mk_status(ST_DATA_R_NACK, 8'hFF));
		put_word(mk_request(7'h55, MODE_READ, 5'd3, 5'd3));
		put_word(mk_drain(5'd31));

		// Unused mode reads, then address refusal and the other failure codes.
		put_word(mk_request(7'h00, 2'd3, 5'd0, 5'd2));
		put_word(mk_status(ST_START, 8'h00));
		put_word(mk_status(ST_ADDR_R_ACK, 8'h00));
		put_word(mk_status(ST_DATA_R_ACK, 8'h00));
		put_word(mk_status(ST_ADDR_R_NACK, 8'h00));
		put_word(mk_status(ST_ARB_LOST, 8'h00));
		put_word(mk_status(ST_DATA_W_NACK, 8'h00));
		put_word(mk_status(ST_ADDR_W_NACK, 8'h00));
		directed_words = words_sent;

		// Mostly whole transfers, the rest loose words of any kind.
		while (words_sent < directed_words + WORD_TARGET) begin
			if ($urandom_range(9) < 7) begin
				run_transfer();
			end else begin
				w = fresh_word();
				if ($urandom_range(1) == 0) begin
					case ($urandom_range(0, 10))
						0: w.status_code = ST_START;
						1: w.status_code = ST_RESTART;
						2: w.status_code = ST_ADDR_W_ACK;
						3: w.status_code = ST_ADDR_W_NACK;
						4: w.status_code = ST_DATA_W_ACK;
						5: w.status_code = ST_DATA_W_NACK;
						6: w.status_code = ST_ARB_LOST;
						7: w.status_code = ST_ADDR_R_ACK;
						8: w.status_code = ST_ADDR_R_NACK;
						9: w.status_code = ST_DATA_R_ACK;
						default: w.status_code = ST_DATA_R_NACK;
					endcase
				end
				put_word(w);
			end
		end
		req_if.valid <= 1'b0;
		idle_on = 1'b1;

		// Let every owed word come out, then allow for a full drain.
		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input words (%0d directed, the rest random transfers and noise).",
			words_sent, directed_words);
		$display("Compared %0d result words field by field; %0d mismatches.",
			checked_count, fail_count);
		if (fail_count == 0 && due_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			if (due_count != 0)
				$error("%0d expected result words never arrived", due_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
